// ----- hw/rtl/dqr_pkg.sv -----
// Shared request, result and command types and codes for the reversible deque.
package dqr_pkg;

  // Request function codes
  localparam logic [2:0] FN_ADD_FRONT = 3'd0;
  localparam logic [2:0] FN_ADD_REAR  = 3'd1;
  localparam logic [2:0] FN_REM_FRONT = 3'd2;
  localparam logic [2:0] FN_REM_REAR  = 3'd3;
  localparam logic [2:0] FN_REVERSE   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic [1:0]         status;
    logic [4:0]         count;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } cmd_t;

endpackage

// ----- hw/rtl/dqr_ctrl.sv -----
// Request sequencer for the reversible deque: latch, execute, respond.
module dqr_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output dqr_pkg::cmd_t cmd
);
  import dqr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy        = (state != S_IDLE);
  assign cmd.load    = (state == S_IDLE) && start;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.respond = (state == S_RESP);

endmodule

// ----- hw/rtl/dqr_datapath.sv -----
// Ring store, head and fill, direction flag and result formatting for the deque.
module dqr_datapath #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  dqr_pkg::cmd_t cmd,
  input  dqr_pkg::req_t req,
  output dqr_pkg::res_t res
);
  import dqr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [2:0]                 func_q;
  logic signed [31:0]         value_q;
  logic [AW-1:0]              head;
  logic [CW-1:0]              fill;
  logic                       rev;
  logic signed [WORD_BITS-1:0] rd_data;
  logic                       rem_ok;
  logic [1:0]                 status_q;

  logic                 is_ins, is_rem, use_low, full, empty, ins_ok, rem_ok_now;
  logic [AW-1:0]        low_dec, high_put, high_take, head_inc, waddr, raddr;
  logic signed [63:0]   wval_wide;
  logic signed [63:0]   rval_wide;

  // Fold a sum below twice the depth back into the ring.
  function automatic logic [AW-1:0] ring_wrap(input logic [CW:0] s);
    logic [CW:0] lim;
    lim = (CW + 1)'(DEPTH);
    if (s >= lim) ring_wrap = AW'(s - lim);
    else          ring_wrap = AW'(s);
  endfunction

  always_comb begin
    is_ins     = (func_q == FN_ADD_FRONT) || (func_q == FN_ADD_REAR);
    is_rem     = (func_q == FN_REM_FRONT) || (func_q == FN_REM_REAR);
    use_low    = ((func_q == FN_ADD_FRONT) || (func_q == FN_REM_FRONT)) != rev;
    full       = (fill == CW'(DEPTH));
    empty      = (fill == '0);
    ins_ok     = is_ins && !full;
    rem_ok_now = is_rem && !empty;
    low_dec    = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
    high_put   = ring_wrap((CW + 1)'(head) + (CW + 1)'(fill));
    high_take  = ring_wrap((CW + 1)'(head) + (CW + 1)'(fill) - 1'b1);
    head_inc   = ring_wrap((CW + 1)'(head) + 1'b1);
    waddr      = use_low ? low_dec : high_put;
    raddr      = use_low ? head : high_take;
    wval_wide  = 64'(value_q);
  end

  // Ring memory: a registered read per executed request, plus a write on insert.
  always_ff @(posedge clk) begin
    if (cmd.exec && ins_ok) mem[waddr] <= wval_wide[WORD_BITS-1:0];
    if (cmd.exec)           rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= req.func;
      value_q <= req.value;
    end
    if (cmd.exec) begin
      rem_ok <= rem_ok_now;
      if (is_ins && full)       status_q <= ST_FULL;
      else if (is_rem && empty) status_q <= ST_EMPTY;
      else                      status_q <= ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      rev  <= 1'b0;
    end else if (cmd.exec) begin
      if (ins_ok) begin
        fill <= fill + 1'b1;
        if (use_low) head <= low_dec;
      end else if (rem_ok_now) begin
        fill <= fill - 1'b1;
        if (use_low) head <= head_inc;
      end else if (func_q == FN_REVERSE) begin
        rev <= ~rev;
      end
    end
  end

  always_comb begin
    rval_wide     = 64'(rd_data);
    res.value_res = rem_ok ? rval_wide[31:0] : 32'sd0;
    res.status    = status_q;
    res.count     = 5'(fill);
  end

endmodule

// ----- hw/rtl/double_ended_queue_reversible_core.sv -----
// Top level of the bounded double-ended queue with constant-time reversal.
// A request is taken when start is high and busy is low; its single result
// appears on res for exactly one cycle, marked by strobe, in the respond state
// after the execute state, and the receiver cannot hold it off. Each request
// goes through the latch, execute and respond steps: the request is latched,
// the ring memory is accessed (a registered read on every request, used for a
// removal, plus a write for an insert) together with the pointer update, and
// the result is presented; busy is high during execute and respond. Insert at
// the front or rear, remove from the front or rear, or reverse: reverse only
// toggles a direction flag that swaps which end of the ring counts as the
// front, so no data moves. An insert into a full queue is dropped with status
// full; a removal from an empty queue returns zero with status empty. count is
// the number of stored words after the request (low five bits). Reset clears
// the head pointer, fill count and direction; the ring contents are not
// cleared, and words outside the occupied range never reach res.
module double_ended_queue_reversible_core #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dqr_pkg::req_t req,
  output logic          strobe,
  output dqr_pkg::res_t res
);
  import dqr_pkg::*;

  cmd_t cmd;

  // Sequence each request through latch, execute and respond.
  dqr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Hold the ring, its head pointer and fill count, and the direction flag.
  dqr_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .res (res)
  );

  // Present the result for exactly the respond cycle.
  assign strobe = cmd.respond;

  // A taken request yields its strobe in the respond state after the execute state.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 strobe)
    else $error("result not delivered two cycles after request");

  // The block frees up straight after a result.
  a_free_after_result: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !busy)
    else $error("still busy after result");

  // A refused insert leaves the queue at full depth.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.status == ST_FULL) |-> (res.count == 5'(DEPTH)))
    else $error("full status with count below depth");

  // Any non-done outcome carries a zero word.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.status != ST_DONE) |-> (res.value_res == 32'sd0))
    else $error("non-zero word on failed request");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the reversible double-ended queue core.
`timescale 1ns / 1ps

module tb;
  import dqr_pkg::*;

  localparam int RING_DEPTH    = 16;
  localparam int RANDOM_ITEMS  = 1130;
  localparam int IDLE_PCT      = 35;
  localparam int CYCLE_LIMIT   = 100000;
  // Result leaves after the execute and respond states; allow some slack.
  localparam int DRAIN_CYCLES  = 8;

  // Operation mix for the random part.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  // Mirror of the deque: holds the ring, the pointers and the direction,
  // and keeps the results still owed by the block in request order.
  class deque_scoreboard;
    res_t               owed_q[$];
    logic signed [31:0] ring [RING_DEPTH];
    int                 head;
    int                 fill;
    bit                 reversed;
    int                 errors;

    function new();
      head     = 0;
      fill     = 0;
      reversed = 1'b0;
      errors   = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function void note_request(req_t r);
      res_t exp_res;
      exp_res.value_res = '0;
      exp_res.status    = ST_DONE;
      case (r.func)
        FN_ADD_FRONT, FN_ADD_REAR: begin
          if (fill >= RING_DEPTH) begin
            exp_res.status = ST_FULL;
          end else if ((r.func == FN_ADD_FRONT) != reversed) begin
            // Insert below the low end: step the head back first.
            head       = (head == 0) ? RING_DEPTH - 1 : head - 1;
            ring[head] = r.value;
            fill++;
          end else begin
            ring[(head + fill) % RING_DEPTH] = r.value;
            fill++;
          end
        end
        FN_REM_FRONT, FN_REM_REAR: begin
          if (fill == 0) begin
            exp_res.status = ST_EMPTY;
          end else if ((r.func == FN_REM_FRONT) != reversed) begin
            exp_res.value_res = ring[head];
            head = (head + 1) % RING_DEPTH;
            fill--;
          end else begin
            exp_res.value_res = ring[(head + fill - 1) % RING_DEPTH];
            fill--;
          end
        end
        FN_REVERSE: begin
          // Only the direction flips; no data moves.
          reversed = !reversed;
        end
        default: begin
          // Unused codes leave everything untouched.
        end
      endcase
      exp_res.count = fill[4:0];
      owed_q.push_back(exp_res);
    endfunction

    // Compare one result from the block with the oldest one owed.
    function void check_result(res_t got);
      res_t exp_res;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: value_res %0d status %0d count %0d",
               got.value_res, got.status, got.count);
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (got.value_res !== exp_res.value_res) begin
        $error("value_res: expected %0d, got %0d", exp_res.value_res, got.value_res);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        errors++;
      end
      if (got.count !== exp_res.count) begin
        $error("count: expected %0d, got %0d", exp_res.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic strobe;
  res_t res;

  deque_scoreboard sb;
  int              cycle_count;

  double_ended_queue_reversible_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .res    (res)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Results cannot be held off: take every strobed result at the edge
  // that ends its cycle.
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) begin
      sb.check_result(res);
    end
  end

  function automatic req_t make_request(logic [2:0] func, logic signed [31:0] value);
    req_t r;
    r.func  = func;
    r.value = value;
    return r;
  endfunction

  // Present one request, called and returning at a falling edge. Idle
  // first at random with noise on the request bus, then hold start until
  // the block takes the request.
  task automatic send_request(input req_t r, input int idle_pct);
    req_t noise;
    while ($urandom_range(99) < idle_pct) begin
      noise.func  = 3'($urandom_range(7));
      noise.value = $urandom;
      start <= 1'b0;
      req   <= noise;
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    // busy is read before the edge updates it, so this is the accepting edge.
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
    @(negedge clk);
  endtask

  initial begin
    mix_t               mix;
    int                 seg_left;
    int                 pick;
    int                 idle_pct;
    req_t               r;
    logic signed [31:0] word;

    sb          = new();
    cycle_count = 0;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;

    // Hold reset, then release it at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty removals, reversal on either side of inserts,
    // word extremes, unused codes, and removing the last word.
    send_request(make_request(FN_REM_FRONT, 32'sd7), IDLE_PCT);
    send_request(make_request(FN_REM_REAR, -32'sd7), IDLE_PCT);
    send_request(make_request(FN_REVERSE, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_ADD_FRONT, 32'sh7FFF_FFFF), IDLE_PCT);
    send_request(make_request(FN_ADD_REAR, 32'sh8000_0000), IDLE_PCT);
    send_request(make_request(FN_REM_FRONT, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REVERSE, -32'sd1), IDLE_PCT);
    send_request(make_request(FN_ADD_FRONT, -32'sd1), IDLE_PCT);
    send_request(make_request(FN_ADD_REAR, 32'sd0), IDLE_PCT);
    send_request(make_request(3'd5, 32'sh5555_5555), IDLE_PCT);
    send_request(make_request(3'd6, 32'shAAAA_AAAA), IDLE_PCT);
    send_request(make_request(3'd7, -32'sd1), IDLE_PCT);
    send_request(make_request(FN_REM_REAR, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REM_FRONT, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REM_FRONT, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REM_REAR, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REVERSE, 32'sd0), IDLE_PCT);
    send_request(make_request(FN_REVERSE, 32'sd0), IDLE_PCT);

    // Random part: segments that mostly fill, mostly drain or stay balanced,
    // so the queue swings between empty and full with reversals throughout.
    mix      = MIX_BALANCED;
    seg_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(2));
        seg_left = $urandom_range(60, 20);
      end
      seg_left--;

      // Keep a long run with back-to-back requests.
      idle_pct = (n >= 400 && n < 700) ? 0 : IDLE_PCT;

      // Bias the word towards its extremes now and then.
      case ($urandom_range(19))
        0:       word = 32'sh8000_0000;
        1:       word = 32'sh7FFF_FFFF;
        2:       word = 32'sd0;
        3:       word = -32'sd1;
        default: word = $urandom;
      endcase

      pick = $urandom_range(99);
      if (pick < 3) begin
        r = make_request(3'($urandom_range(7, 5)), word);
      end else if (pick < 12) begin
        r = make_request(FN_REVERSE, word);
      end else begin
        // Share the rest between inserts and removals by segment mix.
        case (mix)
          MIX_FILL:  pick = $urandom_range(99) < 75;
          MIX_DRAIN: pick = $urandom_range(99) < 25;
          default:   pick = $urandom_range(99) < 50;
        endcase
        if (pick != 0) begin
          r = make_request($urandom_range(1) ? FN_ADD_FRONT : FN_ADD_REAR, word);
        end else begin
          r = make_request($urandom_range(1) ? FN_REM_FRONT : FN_REM_REAR, word);
        end
      end
      send_request(r, idle_pct);
    end

    // Drop start and wait for every owed result, then let the pipe settle.
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
